// File: sv/pras_pkg.sv
// Shared codes and reset constants for the PWM ramp converter controller.
package pras_pkg;

    // Action codes carried by an input beat; the unused code acts as a tick.
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_PRECISE = 2'd1;
    localparam logic [1:0] ACT_FAST    = 2'd2;

    // Register indexes on the configuration port (byte address is 4 times this).
    localparam logic [2:0] REG_PERIOD      = 3'd0;
    localparam logic [2:0] REG_DUTY_STEP   = 3'd1;
    localparam logic [2:0] REG_SPLIT_DUTY  = 3'd2;
    localparam logic [2:0] REG_LOOPS_BELOW = 3'd3;
    localparam logic [2:0] REG_LOOPS_ABOVE = 3'd4;
    localparam logic [2:0] REG_LOOPS_FAST  = 3'd5;

    localparam int unsigned CFG_ADDR_BITS = 5;
    localparam int unsigned CFG_DATA_BITS = 32;
    localparam int unsigned LOOP_BITS     = 8;

    // Register reset values.
    localparam int unsigned RST_PERIOD      = 510;
    localparam int unsigned RST_DUTY_STEP   = 1;
    localparam int unsigned RST_SPLIT_DUTY  = 180;
    localparam int unsigned RST_LOOPS_BELOW = 25;
    localparam int unsigned RST_LOOPS_ABOVE = 12;
    localparam int unsigned RST_LOOPS_FAST  = 5;

endpackage

// File: sv/pras_in_if.sv
// Input channel of the ramp converter: one tick or start command per beat.
interface pras_in_if #(
    parameter int unsigned DUTY_BITS = 10
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic [DUTY_BITS-1:0] start_duty;
    logic                 comparator_low;

    modport source (output valid, output action, output start_duty,
                    output comparator_low, input ready);
    modport sink   (input valid, input action, input start_duty,
                    input comparator_low, output ready);
endinterface

// File: sv/pras_out_if.sv
// Result channel of the ramp converter: pin level and measurement status per beat.
interface pras_out_if #(
    parameter int unsigned DUTY_BITS = 10
);
    logic               valid;
    logic               ready;
    logic               pwm_level;
    logic               busy_res;
    logic               done_res;
    logic [DUTY_BITS:0] result_duty;
    logic               overrange;

    modport source (output valid, output pwm_level, output busy_res, output done_res,
                    output result_duty, output overrange, input ready);
    modport sink   (input valid, input pwm_level, input busy_res, input done_res,
                    input result_duty, input overrange, output ready);
endinterface

// File: sv/pwm_ramp_adc_sweep.sv
// Top level of the PWM and RC ramp converter controller with its register file.
//
//  channel   | modport            | moves per beat
//  ----------+--------------------+-------------------------------------------------
//  i_item    | pras_in_if.sink    | action, start_duty, comparator_low
//  o_res     | pras_out_if.source | pwm_level, busy_res, done_res, result_duty,
//            |                    | overrange
//  APB       | psel .. pready     | 32-bit register writes and reads, 5-bit paddr
//
// Every input beat is processed in the cycle it is accepted: the sweep state and
// the result are computed by one pass of compare and add logic and land in an
// output slot at that edge, so one beat per cycle is sustained while the sink
// keeps taking results. A two-entry output stage (output register plus a skid
// register) lets one more beat be accepted while a result waits; i_item.ready
// drops only when both are full. Reset is synchronous and clears the sweep
// state, the valid flags and the registers to their defaults; no clearing pass.
module pwm_ramp_adc_sweep
    import pras_pkg::*;
#(
    parameter int unsigned DUTY_BITS = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    pras_in_if.sink                  i_item,
    pras_out_if.source               o_res,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    // Duty values carry one bit more than the period so a step can pass the top.
    localparam int unsigned DW = DUTY_BITS + 1;
    // The step add is done at least as wide as the 8-bit step, then cut back.
    localparam int unsigned SW = (DW > LOOP_BITS) ? DW : LOOP_BITS;

    typedef struct packed {
        logic          level;
        logic          busy;
        logic          done;
        logic [DW-1:0] res;
        logic          over;
    } t_res;

    // Configuration registers.
    logic [DUTY_BITS-1:0] r_period;
    logic [LOOP_BITS-1:0] r_duty_step;
    logic [DUTY_BITS-1:0] r_split_duty;
    logic [LOOP_BITS-1:0] r_loops_below;
    logic [LOOP_BITS-1:0] r_loops_above;
    logic [LOOP_BITS-1:0] r_loops_fast;

    // Sweep state.
    logic                 r_sweeping, n_sweeping;
    logic [DW-1:0]        r_duty_now, n_duty_now;
    logic [DUTY_BITS-1:0] r_tick, n_tick;
    logic [LOOP_BITS-1:0] r_periods_left, n_periods_left;
    logic [LOOP_BITS-1:0] r_loops_step, n_loops_step;

    // Output stage.
    logic r_out_v, r_skid_v;
    t_res r_out, r_skid;
    t_res n_res;

    logic                 acc_in;
    logic                 out_take;
    logic                 out_free;
    logic                 cfg_wr;
    logic [2:0]           cfg_idx;
    logic [DUTY_BITS-1:0] last_tick;
    logic [LOOP_BITS-1:0] start_loops;
    logic [DW-1:0]        start_duty_w;
    logic [DW-1:0]        stepped_duty;
    logic [SW-1:0]        step_sum;

    // ------------------------------------------------------------------
    // Configuration port. Writes land in the access phase; reads are plain.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period      <= DUTY_BITS'(RST_PERIOD);
            r_duty_step   <= LOOP_BITS'(RST_DUTY_STEP);
            r_split_duty  <= DUTY_BITS'(RST_SPLIT_DUTY);
            r_loops_below <= LOOP_BITS'(RST_LOOPS_BELOW);
            r_loops_above <= LOOP_BITS'(RST_LOOPS_ABOVE);
            r_loops_fast  <= LOOP_BITS'(RST_LOOPS_FAST);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PERIOD:      r_period      <= pwdata[DUTY_BITS-1:0];
                REG_DUTY_STEP:   r_duty_step   <= pwdata[LOOP_BITS-1:0];
                REG_SPLIT_DUTY:  r_split_duty  <= pwdata[DUTY_BITS-1:0];
                REG_LOOPS_BELOW: r_loops_below <= pwdata[LOOP_BITS-1:0];
                REG_LOOPS_ABOVE: r_loops_above <= pwdata[LOOP_BITS-1:0];
                REG_LOOPS_FAST:  r_loops_fast  <= pwdata[LOOP_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PERIOD:      prdata = CFG_DATA_BITS'(r_period);
            REG_DUTY_STEP:   prdata = CFG_DATA_BITS'(r_duty_step);
            REG_SPLIT_DUTY:  prdata = CFG_DATA_BITS'(r_split_duty);
            REG_LOOPS_BELOW: prdata = CFG_DATA_BITS'(r_loops_below);
            REG_LOOPS_ABOVE: prdata = CFG_DATA_BITS'(r_loops_above);
            REG_LOOPS_FAST:  prdata = CFG_DATA_BITS'(r_loops_fast);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake. The input stalls only when both output slots are full.
    // ------------------------------------------------------------------
    assign i_item.ready = ~r_skid_v;
    assign acc_in       = i_item.valid & i_item.ready;
    assign out_take     = r_out_v & o_res.ready;
    assign out_free     = ~r_out_v | out_take;

    // ------------------------------------------------------------------
    // Sweep step for the accepted beat.
    // ------------------------------------------------------------------
    // A zero period runs as one-tick periods.
    assign last_tick    = (r_period == '0) ? '0 : r_period - 1'b1;
    assign start_loops  = (i_item.start_duty < r_split_duty) ? r_loops_below
                                                             : r_loops_above;
    assign start_duty_w = {1'b0, i_item.start_duty};
    assign step_sum     = SW'(r_duty_now) + SW'(r_duty_step);
    assign stepped_duty = step_sum[DW-1:0];

    always_comb begin
        n_sweeping     = r_sweeping;
        n_duty_now     = r_duty_now;
        n_tick         = r_tick;
        n_periods_left = r_periods_left;
        n_loops_step   = r_loops_step;
        n_res          = '0;

        if (i_item.action == ACT_PRECISE || i_item.action == ACT_FAST) begin
            if (r_sweeping) begin
                // A start while busy is ignored; report the pin as it stands.
                n_res.level = ({1'b0, r_tick} < r_duty_now);
            end else begin
                if (i_item.action == ACT_FAST) begin
                    n_duty_now   = '0;
                    n_loops_step = r_loops_fast;
                end else begin
                    n_duty_now   = start_duty_w;
                    n_loops_step = start_loops;
                end
                n_tick         = '0;
                // A zero loop count runs as a single period per duty.
                n_periods_left = (n_loops_step == '0) ? LOOP_BITS'(1) : n_loops_step;
                if (n_duty_now > {1'b0, r_period}) begin
                    // The start duty is already past the top of the sweep.
                    n_res.done     = 1'b1;
                    n_res.over     = 1'b1;
                    n_res.res      = n_duty_now;
                    n_duty_now     = '0;
                    n_periods_left = '0;
                end else begin
                    n_sweeping = 1'b1;
                end
            end
        end else if (r_sweeping) begin
            n_res.level = ({1'b0, r_tick} < r_duty_now);
            if (r_tick >= last_tick) begin
                n_tick = '0;
                if (r_periods_left > LOOP_BITS'(1)) begin
                    n_periods_left = r_periods_left - 1'b1;
                end else if (i_item.comparator_low) begin
                    // The filtered ramp passed the input: the duty is the result.
                    n_res.done     = 1'b1;
                    n_res.res      = r_duty_now;
                    n_sweeping     = 1'b0;
                    n_periods_left = '0;
                end else begin
                    n_duty_now     = stepped_duty;
                    n_periods_left = (r_loops_step == '0) ? LOOP_BITS'(1) : r_loops_step;
                    if (stepped_duty > {1'b0, r_period}) begin
                        n_res.done     = 1'b1;
                        n_res.over     = 1'b1;
                        n_res.res      = stepped_duty;
                        n_sweeping     = 1'b0;
                        n_periods_left = '0;
                    end
                end
            end else begin
                n_tick = r_tick + 1'b1;
            end
        end
        n_res.busy = n_sweeping;
    end

    // Control state and valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweeping     <= 1'b0;
            r_duty_now     <= '0;
            r_tick         <= '0;
            r_periods_left <= '0;
            r_loops_step   <= '0;
            r_out_v        <= 1'b0;
            r_skid_v       <= 1'b0;
        end else begin
            if (acc_in) begin
                r_sweeping     <= n_sweeping;
                r_duty_now     <= n_duty_now;
                r_tick         <= n_tick;
                r_periods_left <= n_periods_left;
                r_loops_step   <= n_loops_step;
            end
            if (out_free) begin
                r_out_v <= r_skid_v | acc_in;
            end
            if (r_skid_v && out_free) begin
                r_skid_v <= 1'b0;
            end else if (acc_in && !out_free) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    // Result payloads; the skid slot always drains into the output slot first.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (acc_in) begin
                r_out <= n_res;
            end
        end
        if (acc_in && !out_free) begin
            r_skid <= n_res;
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.pwm_level   = r_out.level;
    assign o_res.busy_res    = r_out.busy;
    assign o_res.done_res    = r_out.done;
    assign o_res.result_duty = r_out.res;
    assign o_res.overrange   = r_out.over;

`ifndef SYNTH
    // A finished measurement never leaves the block busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.done |-> !r_out.busy)
        else $error("finished result still reports busy");

    // Idle means no periods are pending, and a sweep always has one left.
    a_idle_no_periods: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sweeping |-> r_periods_left == '0)
        else $error("periods pending while idle");

    a_sweep_has_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sweeping |-> r_periods_left != '0)
        else $error("sweep running with no period left");

    // The skid slot is only ever occupied behind a full output slot.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid slot holds a beat ahead of the output slot");

    // Result duty and overrange read zero unless a measurement finishes.
    a_quiet_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !r_out.done |-> r_out.res == '0 && !r_out.over)
        else $error("result fields set without a finish");
`endif

endmodule
